// ----- sv/mps_pkg.sv -----
// Shared types and constants for the motor phase sequencer.
// No dependencies; imported by mps_step and motor_phase_sequencer.
package mps_pkg;

  localparam int unsigned SPEED_W = 17;
  localparam int unsigned CMD_W   = 18;
  localparam int unsigned DUR_W   = 20;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIBRATION_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_INTERVAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DURATION   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIBRATE_DURATION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_DURATION  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT         = 3'd6;

  // Reset values of the configuration registers
  localparam logic [SPEED_W-1:0] RST_NORMAL_SPEED    = 17'd50;
  localparam logic [SPEED_W-1:0] RST_VIBRATION_SPEED = 17'd5000;
  localparam logic [DUR_W-1:0]   RST_FLIP_INTERVAL   = 20'd100;
  localparam logic [DUR_W-1:0]   RST_MOVE_DURATION   = 20'd50000;
  localparam logic [DUR_W-1:0]   RST_VIBRATE_DURATION = 20'd0;
  localparam logic [DUR_W-1:0]   RST_PAUSE_DURATION  = 20'd0;
  localparam logic [DUR_W-1:0]   RST_LOCKOUT         = 20'd50;

  // Phase codes as reported on the result stream
  localparam logic [1:0] PHASE_CODE_MOVE    = 2'd0;
  localparam logic [1:0] PHASE_CODE_VIBRATE = 2'd1;
  localparam logic [1:0] PHASE_CODE_PAUSE   = 2'd2;

  // Phase state, one-hot
  typedef enum logic [2:0] {
    PH_MOVE    = 3'b001,
    PH_VIBRATE = 3'b010,
    PH_PAUSE   = 3'b100
  } mps_phase_e;

  typedef struct packed {
    logic [SPEED_W-1:0] normal_speed;
    logic [SPEED_W-1:0] vibration_speed;
    logic [DUR_W-1:0]   flip_interval_ms;
    logic [DUR_W-1:0]   move_duration_ms;
    logic [DUR_W-1:0]   vibrate_duration_ms;
    logic [DUR_W-1:0]   pause_duration_ms;
    logic [DUR_W-1:0]   lockout_ms;
  } mps_cfg_t;

  typedef struct packed {
    logic forward_button;
    logic vibrate_button;
    logic stop_button;
  } mps_btn_t;

  // Phase, direction and speed state carried between ticks
  typedef struct packed {
    mps_phase_e              phase;
    logic                    dir_fwd;
    logic signed [CMD_W-1:0] speed;
  } mps_ctl_t;

endpackage

// ----- sv/mps_step.sv -----
// Next-state logic for one millisecond tick of the phase sequencer.
// Depends on mps_pkg for the config, button and control types.
module mps_step import mps_pkg::*; #(
  parameter int unsigned TIMER_BITS = 20
) (
  input  mps_cfg_t              cfg_i,
  input  mps_btn_t              btn_i,
  input  mps_ctl_t              ctl_i,
  input  logic [TIMER_BITS-1:0] phase_tmr_i,
  input  logic [TIMER_BITS-1:0] flip_tmr_i,
  input  logic [TIMER_BITS-1:0] lock_tmr_i,
  output mps_ctl_t              ctl_o,
  output logic [TIMER_BITS-1:0] phase_tmr_o,
  output logic [TIMER_BITS-1:0] flip_tmr_o,
  output logic [TIMER_BITS-1:0] lock_tmr_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;

  logic [TIMER_BITS-1:0] pt_inc, ft_inc, lt_inc;

  // Advance the elapsed timers, holding at full scale
  assign pt_inc = (&phase_tmr_i) ? phase_tmr_i : phase_tmr_i + 1'b1;
  assign ft_inc = (&flip_tmr_i)  ? flip_tmr_i  : flip_tmr_i + 1'b1;
  assign lt_inc = (&lock_tmr_i)  ? lock_tmr_i  : lock_tmr_i + 1'b1;

  always_comb begin
    mps_phase_e              ph;
    logic                    dir;
    logic signed [CMD_W-1:0] spd;
    logic [TIMER_BITS-1:0]   pt, ft, lt;

    ph  = ctl_i.phase;
    dir = ctl_i.dir_fwd;
    spd = ctl_i.speed;
    pt  = pt_inc;
    ft  = ft_inc;
    lt  = lt_inc;

    // Button handling once the debounce lockout has expired
    if (CMP_W'(lt) >= CMP_W'(cfg_i.lockout_ms)) begin
      if (btn_i.stop_button) begin
        ph  = PH_PAUSE;
        pt  = '0;
        ft  = '0;
        spd = '0;
        lt  = '0;
      end else if (btn_i.vibrate_button) begin
        ph = PH_VIBRATE;
        pt = '0;
        ft = '0;
        lt = '0;
      end else if (btn_i.forward_button) begin
        ph = PH_MOVE;
        pt = '0;
        ft = '0;
        lt = '0;
      end
    end

    // Let the current phase act
    case (ph)
      PH_VIBRATE: begin
        if (CMP_W'(ft) >= CMP_W'(cfg_i.flip_interval_ms)) begin
          dir = ~dir;
          ft  = '0;
          spd = dir ? $signed({1'b0, cfg_i.vibration_speed})
                    : -$signed({1'b0, cfg_i.vibration_speed});
        end
        if (CMP_W'(pt) >= CMP_W'(cfg_i.vibrate_duration_ms)) begin
          ph = PH_MOVE;
          pt = '0;
          ft = '0;
        end
      end
      PH_PAUSE: begin
        if (CMP_W'(pt) >= CMP_W'(cfg_i.pause_duration_ms)) begin
          ph = PH_MOVE;
          pt = '0;
          ft = '0;
        end
      end
      default: begin
        spd = $signed({1'b0, cfg_i.normal_speed});
        if (CMP_W'(pt) >= CMP_W'(cfg_i.move_duration_ms)) begin
          ph = PH_VIBRATE;
          pt = '0;
          ft = '0;
        end
      end
    endcase

    ctl_o.phase   = ph;
    ctl_o.dir_fwd = dir;
    ctl_o.speed   = spd;
    phase_tmr_o   = pt;
    flip_tmr_o    = ft;
    lock_tmr_o    = lt;
  end

endmodule

// ----- sv/motor_phase_sequencer.sv -----
// Top level of the motor phase sequencer: config registers, tick input
// register, sequencer state and result register. Uses mps_pkg and mps_step.
//
//   channel   direction  payload (lsb first)
//   s_axis    in         tdata: stop, vibrate, forward button
//   m_axis    out        tdata: speed_command[17:0], phase[1:0]
//   cfg       in         cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained while results are taken; a tick waits
// in the input register and then moves to the result register, where its
// result is offered on m_axis until it is taken.
// The state update is one pass through mps_step.
// Reset loads default config and move phase. A stalled result holds the
// input register; s_axis_tready drops only when both stages are full.
module motor_phase_sequencer import mps_pkg::*; #(
  parameter int unsigned TIMER_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [0] stop_button, [1] vibrate_button, [2] forward_button, [7:3] zero
  input  logic [7:0]           s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [17:0] speed_command, [19:18] phase, [23:20] zero
  output logic [23:0]          m_axis_tdata
);

  mps_cfg_t cfg_q;

  logic     in_vld_q;
  mps_btn_t in_btn_q;

  mps_ctl_t              ctl_q, ctl_d;
  logic [TIMER_BITS-1:0] pt_q, pt_d, ft_q, ft_d, lt_q, lt_d;

  logic              out_vld_q;
  logic [CMD_W-1:0]  out_spd_q;
  logic [1:0]        out_ph_q, ph_code;
  logic              adv, in_acc;

  assign adv           = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = ~in_vld_q | adv;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // Write config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_speed        <= RST_NORMAL_SPEED;
      cfg_q.vibration_speed     <= RST_VIBRATION_SPEED;
      cfg_q.flip_interval_ms    <= RST_FLIP_INTERVAL;
      cfg_q.move_duration_ms    <= RST_MOVE_DURATION;
      cfg_q.vibrate_duration_ms <= RST_VIBRATE_DURATION;
      cfg_q.pause_duration_ms   <= RST_PAUSE_DURATION;
      cfg_q.lockout_ms          <= RST_LOCKOUT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NORMAL_SPEED:     cfg_q.normal_speed        <= cfg_wdata_i[SPEED_W-1:0];
        CFG_VIBRATION_SPEED:  cfg_q.vibration_speed     <= cfg_wdata_i[SPEED_W-1:0];
        CFG_FLIP_INTERVAL:    cfg_q.flip_interval_ms    <= cfg_wdata_i[DUR_W-1:0];
        CFG_MOVE_DURATION:    cfg_q.move_duration_ms    <= cfg_wdata_i[DUR_W-1:0];
        CFG_VIBRATE_DURATION: cfg_q.vibrate_duration_ms <= cfg_wdata_i[DUR_W-1:0];
        CFG_PAUSE_DURATION:   cfg_q.pause_duration_ms   <= cfg_wdata_i[DUR_W-1:0];
        CFG_LOCKOUT:          cfg_q.lockout_ms          <= cfg_wdata_i[DUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the tick request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_btn_q.stop_button    <= s_axis_tdata[0];
      in_btn_q.vibrate_button <= s_axis_tdata[1];
      in_btn_q.forward_button <= s_axis_tdata[2];
    end
  end

  mps_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .cfg_i       (cfg_q),
    .btn_i       (in_btn_q),
    .ctl_i       (ctl_q),
    .phase_tmr_i (pt_q),
    .flip_tmr_i  (ft_q),
    .lock_tmr_i  (lt_q),
    .ctl_o       (ctl_d),
    .phase_tmr_o (pt_d),
    .flip_tmr_o  (ft_d),
    .lock_tmr_o  (lt_d)
  );

  // Advance sequencer state when the tick moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.phase   <= PH_MOVE;
      ctl_q.dir_fwd <= 1'b1;
      ctl_q.speed   <= '0;
      pt_q          <= '0;
      ft_q          <= '0;
      lt_q          <= '0;
    end else if (in_vld_q && adv) begin
      ctl_q <= ctl_d;
      pt_q  <= pt_d;
      ft_q  <= ft_d;
      lt_q  <= lt_d;
    end
  end

  // Encode the phase for the result stream
  always_comb begin
    case (ctl_d.phase)
      PH_VIBRATE: ph_code = PHASE_CODE_VIBRATE;
      PH_PAUSE:   ph_code = PHASE_CODE_PAUSE;
      default:    ph_code = PHASE_CODE_MOVE;
    endcase
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q && adv) begin
      out_spd_q <= ctl_d.speed;
      out_ph_q  <= ph_code;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_ph_q, out_spd_q};

  // Checks
  ap_ready_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled while a stage is free");

  ap_tick_reaches_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && adv) |=> out_vld_q)
    else $error("advanced tick did not reach the result register");

  ap_pause_zero_speed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.phase == PH_PAUSE) |-> (ctl_q.speed == '0))
    else $error("nonzero speed held in pause phase");

  ap_phase_code_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[19:18] != 2'd3))
    else $error("unused phase code on result stream");

endmodule
